// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: always condition");

// consequent that must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// consequent that must hold in the same cycle as the antecedent
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

`endif

// ===== src/aed_pkg.sv =====
// shared types and constants of the archive entry deframer
// no dependencies; used by every module of the block
package aed_pkg;

   localparam int HEADER_BYTES = 48;
   localparam int HDR_CNT_W    = $clog2(HEADER_BYTES);

   // header field positions, big-endian fields
   localparam logic [HDR_CNT_W-1:0] MODE_AT   = HDR_CNT_W'(16);
   localparam logic [HDR_CNT_W-1:0] CTIME_AT  = HDR_CNT_W'(20);
   localparam logic [HDR_CNT_W-1:0] MTIME_AT  = HDR_CNT_W'(28);
   localparam logic [HDR_CNT_W-1:0] NSIZE_AT  = HDR_CNT_W'(36);
   localparam logic [HDR_CNT_W-1:0] FSIZE_AT  = HDR_CNT_W'(40);
   localparam logic [HDR_CNT_W-1:0] FSIZE_END = HDR_CNT_W'(44);
   localparam logic [HDR_CNT_W-1:0] HDR_LAST  = HDR_CNT_W'(HEADER_BYTES - 1);

   // name characters
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_NAME   = 2'd1;
   localparam logic [1:0] KIND_FILE   = 2'd2;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_NAME   = 2'd1,
      PH_FILE   = 2'd2
   } phase_type;

   // one queued byte with its character class
   typedef struct packed {
      logic [7:0] data;
      logic       is_nul;
      logic       is_slash;
      logic       is_dot;
   } entry_type;

   // queue head status seen by the back end
   typedef struct packed {
      logic valid;
   } link_type;

endpackage

// ===== src/archive_entry_deframer.sv =====
// archive entry deframer, top level
// depends on aed_pkg, aed_front, aed_queue, aed_back
//
// usage:
//  - req channel: one archive byte per beat on req_data_byte, valid/ready
//  - rsp channel: one result beat per input byte, in order, tagged with its
//    part (header, name, file data), its offset in that part, the done flags
//    and the header fields as captured so far (complete at header_done)
//  - entry layout: 48-byte header, then name_length name bytes, then
//    data_length file bytes; an empty name or file part is skipped
//  - throughput: one byte per clock, sustained, with rsp_ready held high
//  - path: a byte accepted on req is written into the two-entry queue, then
//    into the result register, from which it is offered on rsp
//  - the framing loop (phase, part counter compare) advances once per popped byte
//  - receiver stall: the result register holds; the queue absorbs up to two
//    more beats, then req_ready drops until rsp drains
//  - reset: synchronous, active high; returns to the start of a header with
//    all header fields zero and both queue and result register empty
module archive_entry_deframer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_part_kind,
   output logic [7:0]         rsp_byte_out,
   output logic [31:0]        rsp_part_offset,
   output logic               rsp_header_done,
   output logic               rsp_name_done,
   output logic               rsp_name_invalid,
   output logic               rsp_entry_done,
   output logic signed [31:0] rsp_entry_mode,
   output logic [63:0]        rsp_create_time,
   output logic [63:0]        rsp_modify_time,
   output logic [31:0]        rsp_name_length,
   output logic [31:0]        rsp_data_length
);

   // front end to queue
   logic               push;
   aed_pkg::entry_type push_entry;

   // queue to back end
   aed_pkg::link_type  head_link;
   aed_pkg::entry_type head_entry;
   logic               head_pop;

   // classify incoming bytes
   aed_front u_front (
      .in_valid   (req_valid),
      .in_byte    (req_data_byte),
      .push       (push),
      .push_entry (push_entry)
   );

   // decouple acceptance from framing
   aed_queue u_queue (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .push_entry    (push_entry),
      .push_ready    (req_ready),
      .head_link_out (head_link),
      .head_pop      (head_pop),
      .head_entry    (head_entry)
   );

   // framing state and result register
   aed_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_link        (head_link),
      .head_entry       (head_entry),
      .head_pop         (head_pop),
      .out_valid        (rsp_valid),
      .out_ready        (rsp_ready),
      .out_part_kind    (rsp_part_kind),
      .out_byte         (rsp_byte_out),
      .out_part_offset  (rsp_part_offset),
      .out_header_done  (rsp_header_done),
      .out_name_done    (rsp_name_done),
      .out_name_invalid (rsp_name_invalid),
      .out_entry_done   (rsp_entry_done),
      .out_entry_mode   (rsp_entry_mode),
      .out_create_time  (rsp_create_time),
      .out_modify_time  (rsp_modify_time),
      .out_name_length  (rsp_name_length),
      .out_data_length  (rsp_data_length)
   );

endmodule

// ===== src/aed_front.sv =====
// front end: classifies each accepted byte for the name check
// depends on aed_pkg
module aed_front (
   input  logic              in_valid,
   input  logic [7:0]        in_byte,
   output logic              push,
   output aed_pkg::entry_type push_entry
);

   assign push                = in_valid;
   assign push_entry.data     = in_byte;
   assign push_entry.is_nul   = (in_byte == aed_pkg::CHAR_NUL);
   assign push_entry.is_slash = (in_byte == aed_pkg::CHAR_SLASH);
   assign push_entry.is_dot   = (in_byte == aed_pkg::CHAR_DOT);

endmodule

// ===== src/aed_queue.sv =====
// two-entry queue between front and back end
// depends on aed_pkg
module aed_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  aed_pkg::entry_type push_entry,
   output logic               push_ready,
   output aed_pkg::link_type  head_link_out,
   input  logic               head_pop,
   output aed_pkg::entry_type head_entry
);

   aed_pkg::entry_type slot_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready          = (count_ff != 2'd2);
   assign do_push             = push && push_ready;
   assign do_pop              = head_pop && (count_ff != 2'd0);
   assign head_link_out.valid = (count_ff != 2'd0);
   assign head_entry          = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== src/aed_back.sv =====
// back end: entry framing state, header capture, name check, result register
// depends on aed_pkg
module aed_back (
   input  logic               clock,
   input  logic               reset,
   input  aed_pkg::link_type  head_link,
   input  aed_pkg::entry_type head_entry,
   output logic               head_pop,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [1:0]         out_part_kind,
   output logic [7:0]         out_byte,
   output logic [31:0]        out_part_offset,
   output logic               out_header_done,
   output logic               out_name_done,
   output logic               out_name_invalid,
   output logic               out_entry_done,
   output logic signed [31:0] out_entry_mode,
   output logic [63:0]        out_create_time,
   output logic [63:0]        out_modify_time,
   output logic [31:0]        out_name_length,
   output logic [31:0]        out_data_length
);

   localparam int CW = aed_pkg::HDR_CNT_W;

   aed_pkg::phase_type phase_ff, phase_in;
   logic [CW-1:0] header_count_ff, header_count_in;
   logic [31:0]   mode_ff, mode_in;
   logic [63:0]   ctime_ff, ctime_in;
   logic [63:0]   mtime_ff, mtime_in;
   logic [31:0]   nsize_ff, nsize_in;
   logic [31:0]   fsize_ff, fsize_in;
   logic [31:0]   part_counter_ff, part_counter_in;
   logic [1:0]    token_len_ff, token_len_in;
   logic          token_dots_ff, token_dots_in;
   logic          bad_ff, bad_in;
   logic          name_ended_ff, name_ended_in;

   logic          out_valid_ff;
   logic [1:0]    kind_ff, kind_in;
   logic [7:0]    byte_ff;
   logic [31:0]   offset_ff, offset_in;
   logic          hdone_ff, hdone_in;
   logic          ndone_ff, ndone_in;
   logic          ninv_ff, ninv_in;
   logic          edone_ff, edone_in;

   logic          pop;
   logic          name_last, file_last, hdr_last;
   logic [7:0]    b;
   logic [1:0]    tl1;
   logic          tad1, bad1;

   assign pop       = head_link.valid && (!out_valid_ff || out_ready);
   assign head_pop  = pop;
   assign b         = head_entry.data;
   assign name_last = (part_counter_ff == nsize_ff - 32'd1);
   assign file_last = (part_counter_ff == fsize_ff - 32'd1);
   assign hdr_last  = (header_count_ff >= aed_pkg::HDR_LAST);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (pop) begin
         unique case (phase_ff)
            aed_pkg::PH_NAME: begin
               if (name_last) begin
                  phase_in = (fsize_ff != 32'd0) ? aed_pkg::PH_FILE : aed_pkg::PH_HEADER;
               end
            end
            aed_pkg::PH_FILE: begin
               if (file_last) begin
                  phase_in = aed_pkg::PH_HEADER;
               end
            end
            default: begin
               if (hdr_last) begin
                  if (nsize_ff != 32'd0) begin
                     phase_in = aed_pkg::PH_NAME;
                  end else if (fsize_ff != 32'd0) begin
                     phase_in = aed_pkg::PH_FILE;
                  end else begin
                     phase_in = aed_pkg::PH_HEADER;
                  end
               end else begin
                  phase_in = aed_pkg::PH_HEADER;
               end
            end
         endcase
      end
   end

   // token tracking for one name byte
   always_comb begin
      tl1           = token_len_ff;
      tad1          = token_dots_ff;
      bad1          = bad_ff;
      name_ended_in = name_ended_ff;
      if (!name_ended_ff) begin
         if (head_entry.is_nul || head_entry.is_slash) begin
            bad1 = bad_ff | (token_dots_ff && (token_len_ff == 2'd1 || token_len_ff == 2'd2));
            tl1  = 2'd0;
            tad1 = 1'b1;
            name_ended_in = head_entry.is_nul;
         end else begin
            tad1 = token_dots_ff & head_entry.is_dot;
            tl1  = (token_len_ff == 2'd3) ? 2'd3 : token_len_ff + 2'd1;
         end
      end
   end

   // datapath and flags
   always_comb begin
      header_count_in = header_count_ff;
      mode_in         = mode_ff;
      ctime_in        = ctime_ff;
      mtime_in        = mtime_ff;
      nsize_in        = nsize_ff;
      fsize_in        = fsize_ff;
      part_counter_in = part_counter_ff;
      token_len_in    = token_len_ff;
      token_dots_in   = token_dots_ff;
      bad_in          = bad_ff;
      kind_in         = aed_pkg::KIND_HEADER;
      offset_in       = part_counter_ff;
      hdone_in        = 1'b0;
      ndone_in        = 1'b0;
      ninv_in         = 1'b0;
      edone_in        = 1'b0;
      unique case (phase_ff)
         aed_pkg::PH_NAME: begin
            kind_in       = aed_pkg::KIND_NAME;
            token_len_in  = tl1;
            token_dots_in = tad1;
            bad_in        = bad1;
            if (name_last) begin
               bad_in          = bad1 | (tad1 && (tl1 == 2'd1 || tl1 == 2'd2));
               token_len_in    = 2'd0;
               token_dots_in   = 1'b1;
               ndone_in        = 1'b1;
               ninv_in         = bad_in;
               part_counter_in = 32'd0;
               edone_in        = (fsize_ff == 32'd0);
            end else begin
               part_counter_in = part_counter_ff + 32'd1;
            end
         end
         aed_pkg::PH_FILE: begin
            kind_in = aed_pkg::KIND_FILE;
            if (file_last) begin
               part_counter_in = 32'd0;
               edone_in        = 1'b1;
            end else begin
               part_counter_in = part_counter_ff + 32'd1;
            end
         end
         default: begin
            offset_in = {{(32-CW){1'b0}}, header_count_ff};
            if (header_count_ff >= aed_pkg::MODE_AT && header_count_ff < aed_pkg::CTIME_AT) begin
               mode_in = {mode_ff[23:0], b};
            end else if (header_count_ff >= aed_pkg::CTIME_AT &&
                         header_count_ff < aed_pkg::MTIME_AT) begin
               ctime_in = {ctime_ff[55:0], b};
            end else if (header_count_ff >= aed_pkg::MTIME_AT &&
                         header_count_ff < aed_pkg::NSIZE_AT) begin
               mtime_in = {mtime_ff[55:0], b};
            end else if (header_count_ff >= aed_pkg::NSIZE_AT &&
                         header_count_ff < aed_pkg::FSIZE_AT) begin
               nsize_in = {nsize_ff[23:0], b};
            end else if (header_count_ff >= aed_pkg::FSIZE_AT &&
                         header_count_ff < aed_pkg::FSIZE_END) begin
               fsize_in = {fsize_ff[23:0], b};
            end
            if (hdr_last) begin
               hdone_in        = 1'b1;
               header_count_in = '0;
               part_counter_in = 32'd0;
               token_len_in    = 2'd0;
               token_dots_in   = 1'b1;
               bad_in          = 1'b0;
               edone_in        = (nsize_ff == 32'd0) && (fsize_ff == 32'd0);
            end else begin
               header_count_in = header_count_ff + CW'(1);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= aed_pkg::PH_HEADER;
         header_count_ff <= '0;
         mode_ff         <= '0;
         ctime_ff        <= '0;
         mtime_ff        <= '0;
         nsize_ff        <= '0;
         fsize_ff        <= '0;
         part_counter_ff <= '0;
         token_len_ff    <= 2'd0;
         token_dots_ff   <= 1'b1;
         bad_ff          <= 1'b0;
         name_ended_ff   <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff        <= phase_in;
            header_count_ff <= header_count_in;
            mode_ff         <= mode_in;
            ctime_ff        <= ctime_in;
            mtime_ff        <= mtime_in;
            nsize_ff        <= nsize_in;
            fsize_ff        <= fsize_in;
            part_counter_ff <= part_counter_in;
            token_len_ff    <= token_len_in;
            token_dots_ff   <= token_dots_in;
            bad_ff          <= bad_in;
            // a finished header opens a fresh name
            name_ended_ff   <= ((phase_ff != aed_pkg::PH_NAME) && (phase_ff != aed_pkg::PH_FILE))
                               ? (hdr_last ? 1'b0 : name_ended_ff)
                               : ((phase_ff == aed_pkg::PH_NAME) ? name_ended_in : name_ended_ff);
         end
         if (pop) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff   <= kind_in;
         byte_ff   <= b;
         offset_ff <= offset_in;
         hdone_ff  <= hdone_in;
         ndone_ff  <= ndone_in;
         ninv_ff   <= ninv_in;
         edone_ff  <= edone_in;
      end
   end

   assign out_valid        = out_valid_ff;
   assign out_part_kind    = kind_ff;
   assign out_byte         = byte_ff;
   assign out_part_offset  = offset_ff;
   assign out_header_done  = hdone_ff;
   assign out_name_done    = ndone_ff;
   assign out_name_invalid = ninv_ff;
   assign out_entry_done   = edone_ff;
   // header registers only change on a pop, so they track the result register
   assign out_entry_mode   = mode_ff;
   assign out_create_time  = ctime_ff;
   assign out_modify_time  = mtime_ff;
   assign out_name_length  = nsize_ff;
   assign out_data_length  = fsize_ff;

endmodule

// ===== src/aed_checker.sv =====
// port-level checks for the archive entry deframer, bound to the top level
// depends on aed_pkg and assert_macros.svh
`include "assert_macros.svh"

module aed_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_part_kind,
   input logic [7:0]  rsp_byte_out,
   input logic [31:0] rsp_part_offset,
   input logic        rsp_header_done,
   input logic        rsp_name_done,
   input logic        rsp_name_invalid
);

   logic        rsp_stall;
   logic [39:0] rsp_beat;
   logic        hdone_at_end;

   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign rsp_beat     = {rsp_byte_out, rsp_part_offset};
   assign hdone_at_end = (rsp_part_kind == aed_pkg::KIND_HEADER) &&
                         (rsp_part_offset == 32'(aed_pkg::HEADER_BYTES - 1));

   // a stalled result beat holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_beat))

   // invalid name only reported with the name end
   `ASSERT_SAME(a_inv_with_done, clock, reset, rsp_valid && rsp_name_invalid, rsp_name_done)

   // name end only on a name byte
   `ASSERT_SAME(a_ndone_kind, clock, reset, rsp_valid && rsp_name_done, rsp_part_kind == aed_pkg::KIND_NAME)

   // header end only on the last header byte
   `ASSERT_SAME(a_hdone_pos, clock, reset, rsp_valid && rsp_header_done, hdone_at_end)

   // unused part code never shows
   `ASSERT_ALWAYS(a_kind_legal, clock, reset, !rsp_valid || rsp_part_kind <= aed_pkg::KIND_FILE)

endmodule

bind archive_entry_deframer aed_checker u_aed_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_part_kind    (rsp_part_kind),
   .rsp_byte_out     (rsp_byte_out),
   .rsp_part_offset  (rsp_part_offset),
   .rsp_header_done  (rsp_header_done),
   .rsp_name_done    (rsp_name_done),
   .rsp_name_invalid (rsp_name_invalid)
);
